/* rtl/core/intel_hex_record_decoder_top_defines.svh */
// Assertion macros for the Intel HEX record decoder.
// Used by the modules that carry concurrent checks; depends on nothing else.
`ifndef INTEL_HEX_RECORD_DECODER_TOP_DEFINES_SVH
`define INTEL_HEX_RECORD_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define IHEX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ihex check failed");

// Next-cycle implication, disabled while reset is asserted
`define IHEX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ihex check failed");

`endif

/* rtl/core/ihex_pkg.sv */
// Shared types and constants of the Intel HEX record decoder.
// No dependencies; imported by the top, ihex_front and ihex_back.
package ihex_pkg;

	localparam int unsigned POS_W = 10;
	localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
	// ':' plus count, address, type and checksum digit pairs
	localparam logic [POS_W-1:0] HEADER_CHARS = 10'd11;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF = 8'h01;

	// line flag bit positions
	localparam int unsigned FLAG_BAD_START = 0;
	localparam int unsigned FLAG_BAD_COUNT = 1;
	localparam int unsigned FLAG_BAD_DIGIT = 2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EOF       = 3'd1,
		ST_BAD_START = 3'd2,
		ST_BAD_DIGIT = 3'd3,
		ST_SHORT     = 3'd4,
		ST_BAD_TYPE  = 3'd5,
		ST_CHECKSUM  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		MODE_RUNNING = 2'd0,
		MODE_HALTED  = 2'd1
	} run_mode_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	// classified character handed from front to back
	typedef struct packed {
		logic       is_newline;
		logic       is_colon;
		logic       digit_ok;
		logic [3:0] digit_val;
	} char_class_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] byte_address;
		logic [7:0]  data_byte;
		status_t     status;
	} result_t;

endpackage

/* rtl/core/intel_hex_record_decoder_top.sv */
// Intel HEX record decoder: usage
// Input is a queue-style channel: a character transfers at a rising edge with push
// high and full low. Results come out of a queue: while empty is low the oldest
// result sits on kind, byte_address, data_byte and status, and it transfers at an
// edge with pop high. A front classifier fills a character queue; the record
// engine drains it into the result queue, so either side may stall on its own.
// A character is held in the character queue and its result in the result queue before
// the result reaches the result ports; it also waits behind any older results.
// Throughput: one character per cycle while the receiver keeps popping; the record engine
// handles one character per cycle and stops only while the result queue is full.
// Data bytes of a clean type 00 record come out as their second digit arrives;
// every newline gives a status result. Any status other than ok data halts the
// decoder: characters are still taken but dropped until reset.
// Reset (arst_n low) empties both queues and clears the record state.
// While the receiver withholds pop, results wait in order and full rises once
// both queues back up; nothing is lost.
// Depends on ihex_pkg, ihex_front, ihex_queue and ihex_back.
module intel_hex_record_decoder_top #(
	parameter int unsigned CHAR_QUEUE_DEPTH = 2,
	parameter int unsigned RESULT_QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  character,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [15:0] byte_address,
	output logic [7:0]  data_byte,
	output logic [2:0]  status
);
	import ihex_pkg::*;

	char_class_t cls, mid_cls;
	result_t     res, out_res;
	logic        mid_empty, mid_take, res_full, res_valid;

	ihex_front u_front (
		.character (character),
		.cls       (cls)
	);

	// classified characters awaiting the record engine
	ihex_queue #(
		.WIDTH ($bits(char_class_t)),
		.DEPTH (CHAR_QUEUE_DEPTH)
	) u_char_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls),
		.full    (full),
		.rd_en   (mid_take),
		.rd_data (mid_cls),
		.empty   (mid_empty)
	);

	ihex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!mid_empty),
		.in_cls    (mid_cls),
		.in_take   (mid_take),
		.out_full  (res_full),
		.res_valid (res_valid),
		.res       (res)
	);

	// results awaiting transfer
	ihex_queue #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RESULT_QUEUE_DEPTH)
	) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (out_res),
		.empty   (empty)
	);

	assign kind         = out_res.kind;
	assign byte_address = out_res.byte_address;
	assign data_byte    = out_res.data_byte;
	assign status       = out_res.status;

endmodule

/* rtl/core/ihex_front.sv */
// Character classifier of the Intel HEX decoder: newline, colon, hex digit value.
// Depends on ihex_pkg.
module ihex_front (
	input  logic [7:0]           character,
	output ihex_pkg::char_class_t cls
);
	import ihex_pkg::*;

	// decode one character, digits in either case
	always_comb begin
		cls.is_newline = (character == CHAR_NEWLINE);
		cls.is_colon   = (character == CHAR_COLON);
		cls.digit_ok   = 1'b1;
		cls.digit_val  = 4'd0;
		if (character >= 8'h30 && character <= 8'h39) begin
			cls.digit_val = character[3:0];
		end else if ((character >= 8'h41 && character <= 8'h46) ||
				(character >= 8'h61 && character <= 8'h66)) begin
			cls.digit_val = character[3:0] + 4'd9;
		end else begin
			cls.digit_ok = 1'b0;
		end
	end

endmodule

/* rtl/core/ihex_queue.sv */
// Small register queue used between the decoder stages and on the result side.
// Depends on nothing; width and depth come from parameters.
module ihex_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	// store incoming entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/ihex_back.sv */
// Record state engine of the Intel HEX decoder: header fields, data bytes, line status.
// Depends on ihex_pkg and the assertion macro header.
module ihex_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  ihex_pkg::char_class_t in_cls,
	output logic                  in_take,
	input  logic                  out_full,
	output logic                  res_valid,
	output ihex_pkg::result_t     res
);
	import ihex_pkg::*;
	`include "intel_hex_record_decoder_top_defines.svh"

	run_mode_t         mode_q, mode_d;
	logic [POS_W-1:0]  pos_q;
	logic [3:0]        hi_q;
	logic [7:0]        cnt_q, type_q, sum_q;
	logic [15:0]       addr_q;
	logic [2:0]        flags_q;

	logic              running, step, in_range;
	logic [10:0]       digit_limit;
	logic [POS_W-1:0]  need, dig_pos;
	logic [8:0]        idx, data_idx;
	logic [3:0]        nib;
	logic [7:0]        byte_val;
	logic [2:0]        flags_d;
	logic              is_high, is_data, emit;
	status_t           line_st;

	assign running = (mode_q == MODE_RUNNING);
	assign in_take = in_valid && !out_full;
	assign step    = in_take && running;

	// locate the character within the record
	always_comb begin
		digit_limit = 11'd10 + {2'b00, cnt_q, 1'b0};
		need        = HEADER_CHARS + {1'b0, cnt_q, 1'b0};
		in_range    = (pos_q <= 10'd2) || ({1'b0, pos_q} <= digit_limit);
		dig_pos     = pos_q - 1'b1;
		idx         = dig_pos[POS_W-1:1];
		data_idx    = idx - 9'd4;
		is_high     = !dig_pos[0];
		nib         = in_cls.digit_ok ? in_cls.digit_val : 4'd0;
		byte_val    = {hi_q, nib};
		is_data     = (idx >= 9'd4) && (data_idx < {1'b0, cnt_q});
		flags_d     = flags_q;
		if (pos_q != '0 && in_range && !in_cls.digit_ok) begin
			if (pos_q <= 10'd2) begin
				flags_d[FLAG_BAD_COUNT] = 1'b1;
			end else begin
				flags_d[FLAG_BAD_DIGIT] = 1'b1;
			end
		end
		emit = (pos_q != '0) && in_range && !is_high && is_data &&
			(flags_d == 3'b000) && (type_q == REC_DATA);
	end

	// rank the line status at newline
	always_comb begin
		if (pos_q == '0 || flags_q[FLAG_BAD_START]) begin
			line_st = ST_BAD_START;
		end else if (flags_q[FLAG_BAD_COUNT]) begin
			line_st = ST_BAD_DIGIT;
		end else if (pos_q < need) begin
			line_st = ST_SHORT;
		end else if (flags_q[FLAG_BAD_DIGIT]) begin
			line_st = ST_BAD_DIGIT;
		end else if (type_q == REC_EOF) begin
			line_st = ST_EOF;
		end else if (type_q != REC_DATA) begin
			line_st = ST_BAD_TYPE;
		end else if (sum_q != 8'd0) begin
			line_st = ST_CHECKSUM;
		end else begin
			line_st = ST_OK;
		end
	end

	// drive the result
	always_comb begin
		res.kind         = KIND_DATA;
		res.byte_address = addr_q + {7'd0, data_idx};
		res.data_byte    = byte_val;
		res.status       = ST_OK;
		res_valid        = 1'b0;
		if (in_cls.is_newline) begin
			res.kind         = KIND_STATUS;
			res.byte_address = addr_q;
			res.data_byte    = 8'd0;
			res.status       = line_st;
			res_valid        = step;
		end else begin
			res_valid = step && emit;
		end
	end

	// run mode: halt on any status other than clean data
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			MODE_RUNNING: begin
				if (step && in_cls.is_newline && line_st != ST_OK) begin
					mode_d = MODE_HALTED;
				end
			end
			MODE_HALTED: mode_d = MODE_HALTED;
			default: mode_d = MODE_HALTED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RUNNING;
		end else begin
			mode_q <= mode_d;
		end
	end

	// update line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hi_q    <= '0;
			cnt_q   <= '0;
			addr_q  <= '0;
			type_q  <= '0;
			sum_q   <= '0;
			flags_q <= '0;
		end else if (step) begin
			if (in_cls.is_newline) begin
				pos_q   <= '0;
				hi_q    <= '0;
				cnt_q   <= '0;
				addr_q  <= '0;
				type_q  <= '0;
				sum_q   <= '0;
				flags_q <= '0;
			end else begin
				if (pos_q == '0) begin
					if (!in_cls.is_colon) begin
						flags_q[FLAG_BAD_START] <= 1'b1;
					end
				end else if (in_range) begin
					flags_q <= flags_d;
					if (is_high) begin
						hi_q <= nib;
					end else begin
						sum_q <= sum_q + byte_val;
						case (idx)
							9'd0: cnt_q <= byte_val;
							9'd1: addr_q[15:8] <= byte_val;
							9'd2: addr_q[7:0] <= byte_val;
							9'd3: type_q <= byte_val;
							default: ;
						endcase
					end
				end
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	`IHEX_ASSERT_NEXT(a_halt_sticks, clk, arst_n, mode_q == MODE_HALTED,
		mode_q == MODE_HALTED)
	`IHEX_ASSERT_NOW(a_no_result_halted, clk, arst_n, mode_q == MODE_HALTED,
		!res_valid)
	`IHEX_ASSERT_NOW(a_data_clean, clk, arst_n, res_valid && res.kind == KIND_DATA,
		res.status == ST_OK && flags_q == 3'b000 && type_q == REC_DATA)
	`IHEX_ASSERT_NEXT(a_bad_status_halts, clk, arst_n,
		res_valid && res.kind == KIND_STATUS && res.status != ST_OK,
		mode_q == MODE_HALTED && pos_q == '0)

endmodule
